// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the rational arithmetic unit RTL.
// Every macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define RAU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rau_pkg.sv -----
// Package for the rational arithmetic unit: widths, opcodes, status codes,
// controller states and the status struct of the serial units. No dependencies.
package rau_pkg;

  localparam int WordBits    = 32;
  localparam int FieldBits   = 32;
  localparam int DenOutBits  = 31;
  localparam int ProdBits    = 2 * WordBits;
  localparam int MulCntBits  = $clog2(WordBits);
  localparam int DivCntBits  = $clog2(ProdBits);
  localparam int ShiftBits   = $clog2(ProdBits + 1);

  typedef enum logic [2:0] {
    OpAdd  = 3'd0,
    OpSub  = 3'd1,
    OpMul  = 3'd2,
    OpDiv  = 3'd3,
    OpCmp  = 3'd4,
    OpNorm = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StZeroDen  = 2'd1,
    StOverflow = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SMul,
    SComb,
    SGcd,
    SDiv,
    SFin,
    SOut
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

// ----- rtl/core/rau_mul.sv -----
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on rau_pkg for widths and the unit status struct.
module rau_mul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [rau_pkg::WordBits-1:0]      a_i,
  input  logic [rau_pkg::WordBits-1:0]      b_i,
  output rau_pkg::unit_sts_t                sts_o,
  output logic [rau_pkg::ProdBits-1:0]      prod_o
);

  logic                             busy_q, done_q;
  logic [rau_pkg::MulCntBits-1:0]   cnt_q;
  logic [rau_pkg::ProdBits-1:0]     acc_q, mc_q;
  logic [rau_pkg::WordBits-1:0]     mp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == rau_pkg::MulCntBits'(rau_pkg::WordBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      mc_q  <= rau_pkg::ProdBits'(a_i);
      mp_q  <= b_i;
    end else if (busy_q) begin
      if (mp_q[0]) begin
        acc_q <= acc_q + mc_q;
      end
      mc_q <= {mc_q[rau_pkg::ProdBits-2:0], 1'b0};
      mp_q <= {1'b0, mp_q[rau_pkg::WordBits-1:1]};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign prod_o     = acc_q;

endmodule

// ----- rtl/core/rau_gcd.sv -----
// Binary GCD unit: one shift or one subtraction per cycle, then the common
// power of two is shifted back in one bit per cycle. Depends on rau_pkg.
module rau_gcd (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [rau_pkg::ProdBits-1:0]      x_i,
  input  logic [rau_pkg::ProdBits-1:0]      y_i,
  output rau_pkg::unit_sts_t                sts_o,
  output logic [rau_pkg::ProdBits-1:0]      gcd_o
);

  logic                            busy_q, shift_q, done_q;
  logic [rau_pkg::ShiftBits-1:0]   k_q;
  logic [rau_pkg::ProdBits-1:0]    u_q, v_q;
  logic                            zero_hit;

  assign zero_hit = (u_q == '0) || (v_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      shift_q <= 1'b0;
      done_q  <= 1'b0;
      k_q     <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        k_q    <= '0;
      end else if (busy_q && !shift_q) begin
        if (zero_hit) begin
          shift_q <= 1'b1;
        end else if (!u_q[0] && !v_q[0]) begin
          k_q <= k_q + 1'b1;
        end
      end else if (shift_q) begin
        if (k_q == '0) begin
          shift_q <= 1'b0;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end else begin
          k_q <= k_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      u_q <= x_i;
      v_q <= y_i;
    end else if (busy_q && !shift_q) begin
      if (zero_hit) begin
        u_q <= u_q | v_q;
      end else if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1;
        v_q <= v_q >> 1;
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (u_q >= v_q) begin
        u_q <= u_q - v_q;
      end else begin
        v_q <= v_q - u_q;
      end
    end else if (shift_q && (k_q != '0)) begin
      u_q <= u_q << 1;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign gcd_o      = u_q;

endmodule

// ----- rtl/core/rau_div.sv -----
// Restoring divider producing one quotient bit per cycle.
// Depends on rau_pkg for widths and the unit status struct.
module rau_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [rau_pkg::ProdBits-1:0]      num_i,
  input  logic [rau_pkg::ProdBits-1:0]      den_i,
  output rau_pkg::unit_sts_t                sts_o,
  output logic [rau_pkg::ProdBits-1:0]      quo_o
);

  logic                             busy_q, done_q;
  logic [rau_pkg::DivCntBits-1:0]   cnt_q;
  logic [rau_pkg::ProdBits-1:0]     rem_q, quo_q, d_q;
  logic [rau_pkg::ProdBits:0]       trial, diff;
  logic                             fits;

  assign trial = {rem_q, quo_q[rau_pkg::ProdBits-1]};
  assign diff  = trial - {1'b0, d_q};
  assign fits  = trial >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == rau_pkg::DivCntBits'(rau_pkg::ProdBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      d_q   <= den_i;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so the top trial bit drops out.
      rem_q <= fits ? diff[rau_pkg::ProdBits-1:0] : trial[rau_pkg::ProdBits-1:0];
      quo_q <= {quo_q[rau_pkg::ProdBits-2:0], fits};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = quo_q;

endmodule

// ----- rtl/core/rational_arithmetic_unit_core.sv -----
// Rational arithmetic unit top level: controller, operand split and result
// packing. Depends on rau_pkg, rau_mul, rau_gcd, rau_div and assert_macros.svh.

// One beat in gives one beat out. An item with a zero denominator, a divide
// by a zero fraction or an unknown opcode goes from idle straight to the output
// state and skips the serial units. Otherwise the item runs through two or
// three bit-serial multiplications (three for add, subtract and compare), a
// binary GCD on the 2*WordBits-bit result numerator and denominator (one shift
// or subtract per cycle, then the common power of two is shifted back in) and
// two restoring divisions, of the numerator and then the denominator by the
// GCD. Compare skips the GCD and the divisions; a zero result skips them too.
// A new beat is taken as soon as the controller is back in idle, even while
// the previous result still waits in the output register.
`include "assert_macros.svh"

module rational_arithmetic_unit_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [2:0]                           opcode_i,
  input  logic signed [rau_pkg::FieldBits-1:0] a_num_i,
  input  logic signed [rau_pkg::FieldBits-1:0] a_den_i,
  input  logic signed [rau_pkg::FieldBits-1:0] b_num_i,
  input  logic signed [rau_pkg::FieldBits-1:0] b_den_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [rau_pkg::FieldBits-1:0] res_num_o,
  output logic [rau_pkg::DenOutBits-1:0]       res_den_o,
  output logic                                 is_less_o,
  output logic                                 is_equal_o,
  output logic [1:0]                           status_o
);

  localparam int W = rau_pkg::WordBits;
  localparam int P = rau_pkg::ProdBits;
  localparam logic [P-1:0] HalfVal = P'(64'd1 << (W - 1));

  function automatic logic [W-1:0] mag_of(input logic [rau_pkg::FieldBits-1:0] x);
    logic [W-1:0] v;
    v = x[W-1:0];
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  rau_pkg::state_e  state_q, state_d;
  rau_pkg::opcode_e op_q;

  logic         sa_q, sb_q;
  logic [W-1:0] an_q, ad_q, bn_q, bd_q;
  logic [1:0]   mi_q, mi_last;
  logic         mstart_q, dstart_q, di_q;
  logic [P-1:0] m0_q, m1_q, m2_q;
  logic [P-1:0] rn_q, rd_q, g_q, qn_q, qd_q;
  logic         rs_q;

  logic [rau_pkg::FieldBits-1:0]  wr_num_q, out_num_q;
  logic [rau_pkg::DenOutBits-1:0] wr_den_q, out_den_q;
  logic                           wr_less_q, wr_eq_q, out_less_q, out_eq_q;
  rau_pkg::status_e               wr_st_q, out_st_q;
  logic                           out_valid_q;

  // Accept-time operand split and checks.
  logic [W-1:0] in_an, in_ad, in_bn, in_bd;
  logic         in_sa, in_sb, in_known, in_err;

  // Serial unit hookup.
  rau_pkg::unit_sts_t mul_sts, gcd_sts, div_sts;
  logic               mul_start, gcd_start, div_start, out_free;
  logic [W-1:0]       mul_a, mul_b;
  logic [P-1:0]       mul_p, gcd_g, div_q, div_n;

  // Combine step.
  logic         c_sbx, c_rs;
  logic [P-1:0] c_rn, c_rd;

  // Final packing.
  logic [W-1:0] fin_nw;
  logic         fin_ovf;

  assign in_an = mag_of(a_num_i);
  assign in_ad = mag_of(a_den_i);
  assign in_bn = mag_of(b_num_i);
  assign in_bd = mag_of(b_den_i);
  assign in_sa = (a_num_i[W-1] ^ a_den_i[W-1]) && (in_an != '0);
  assign in_sb = (b_num_i[W-1] ^ b_den_i[W-1]) && (in_bn != '0);

  always_comb begin
    case (rau_pkg::opcode_e'(opcode_i))
      rau_pkg::OpAdd, rau_pkg::OpSub, rau_pkg::OpMul,
      rau_pkg::OpDiv, rau_pkg::OpCmp:
        in_known = 1'b1;
      rau_pkg::OpNorm: in_known = 1'b1;
      default:         in_known = 1'b0;
    endcase
  end

  assign in_err = (in_ad == '0)
               || ((rau_pkg::opcode_e'(opcode_i) != rau_pkg::OpNorm) && (in_bd == '0))
               || ((rau_pkg::opcode_e'(opcode_i) == rau_pkg::OpDiv) && (in_bn == '0));

  always_comb begin
    mi_last = 2'd1;
    mul_a   = an_q;
    mul_b   = bd_q;
    case (op_q)
      rau_pkg::OpAdd, rau_pkg::OpSub, rau_pkg::OpCmp: begin
        mi_last = 2'd2;
        case (mi_q)
          2'd0:    begin mul_a = an_q; mul_b = bd_q; end
          2'd1:    begin mul_a = bn_q; mul_b = ad_q; end
          default: begin mul_a = ad_q; mul_b = bd_q; end
        endcase
      end
      rau_pkg::OpMul: begin
        mul_a = (mi_q == 2'd0) ? an_q : ad_q;
        mul_b = (mi_q == 2'd0) ? bn_q : bd_q;
      end
      rau_pkg::OpDiv: begin
        mul_a = (mi_q == 2'd0) ? an_q : ad_q;
        mul_b = (mi_q == 2'd0) ? bd_q : bn_q;
      end
      rau_pkg::OpNorm: begin
        mul_a = (mi_q == 2'd0) ? an_q : ad_q;
        mul_b = W'(1);
      end
      default: begin
        mul_a = an_q;
        mul_b = bd_q;
      end
    endcase
  end

  // Sign-magnitude sum of the cross products for add, subtract and compare; other opcodes pass both products through.
  always_comb begin
    c_sbx = (op_q == rau_pkg::OpAdd) ? sb_q : !sb_q;
    c_rn  = m0_q;
    c_rd  = m1_q;
    c_rs  = sa_q ^ sb_q;
    case (op_q)
      rau_pkg::OpAdd, rau_pkg::OpSub, rau_pkg::OpCmp: begin
        c_rd = m2_q;
        if (sa_q == c_sbx) begin
          c_rs = sa_q;
          c_rn = m0_q + m1_q;
        end else if (m0_q >= m1_q) begin
          c_rs = sa_q;
          c_rn = m0_q - m1_q;
        end else begin
          c_rs = c_sbx;
          c_rn = m1_q - m0_q;
        end
      end
      rau_pkg::OpNorm: c_rs = sa_q;
      default:         c_rs = sa_q ^ sb_q;
    endcase
    if (c_rn == '0) begin
      c_rs = 1'b0;
    end
  end

  assign fin_ovf = (qd_q > (HalfVal - 1'b1))
                || (qn_q > (rs_q ? HalfVal : (HalfVal - 1'b1)));
  assign fin_nw  = rs_q ? (~qn_q[W-1:0] + 1'b1) : qn_q[W-1:0];
  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rau_pkg::SIdle: begin
        if (in_valid_i) begin
          state_d = (!in_known || in_err) ? rau_pkg::SOut : rau_pkg::SMul;
        end
      end
      rau_pkg::SMul: begin
        if (mul_sts.done && (mi_q == mi_last)) begin
          state_d = rau_pkg::SComb;
        end
      end
      rau_pkg::SComb: begin
        if (op_q == rau_pkg::OpCmp) begin
          state_d = rau_pkg::SOut;
        end else if (c_rn == '0) begin
          state_d = rau_pkg::SFin;
        end else begin
          state_d = rau_pkg::SGcd;
        end
      end
      rau_pkg::SGcd: begin
        if (gcd_sts.done) begin
          state_d = rau_pkg::SDiv;
        end
      end
      rau_pkg::SDiv: begin
        if (div_sts.done && di_q) begin
          state_d = rau_pkg::SFin;
        end
      end
      rau_pkg::SFin: state_d = rau_pkg::SOut;
      rau_pkg::SOut: begin
        if (out_free) begin
          state_d = rau_pkg::SIdle;
        end
      end
      default: state_d = rau_pkg::SIdle;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_ready_o = (state_q == rau_pkg::SIdle);
    mul_start  = (state_q == rau_pkg::SMul) && mstart_q;
    gcd_start  = (state_q == rau_pkg::SComb) && (state_d == rau_pkg::SGcd);
    div_start  = (state_q == rau_pkg::SDiv) && dstart_q;
  end

  assign div_n = di_q ? rd_q : rn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rau_pkg::SIdle;
      mstart_q    <= 1'b0;
      dstart_q    <= 1'b0;
      mi_q        <= '0;
      di_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mstart_q <= 1'b0;
      dstart_q <= 1'b0;
      if (state_q == rau_pkg::SIdle && in_valid_i) begin
        mi_q     <= '0;
        mstart_q <= in_known && !in_err;
      end
      if (state_q == rau_pkg::SMul && mul_sts.done && (mi_q != mi_last)) begin
        mi_q     <= mi_q + 1'b1;
        mstart_q <= 1'b1;
      end
      if (state_q == rau_pkg::SGcd && gcd_sts.done) begin
        di_q     <= 1'b0;
        dstart_q <= 1'b1;
      end
      if (state_q == rau_pkg::SDiv && div_sts.done && !di_q) begin
        di_q     <= 1'b1;
        dstart_q <= 1'b1;
      end
      if (state_q == rau_pkg::SOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      rau_pkg::SIdle: begin
        if (in_valid_i) begin
          op_q      <= rau_pkg::opcode_e'(opcode_i);
          an_q      <= in_an;
          ad_q      <= in_ad;
          bn_q      <= in_bn;
          bd_q      <= in_bd;
          sa_q      <= in_sa;
          sb_q      <= in_sb;
          wr_num_q  <= '0;
          wr_den_q  <= '0;
          wr_less_q <= 1'b0;
          wr_eq_q   <= 1'b0;
          wr_st_q   <= (in_known && in_err) ? rau_pkg::StZeroDen : rau_pkg::StOk;
        end
      end
      rau_pkg::SMul: begin
        if (mul_sts.done) begin
          case (mi_q)
            2'd0:    m0_q <= mul_p;
            2'd1:    m1_q <= mul_p;
            default: m2_q <= mul_p;
          endcase
        end
      end
      rau_pkg::SComb: begin
        rn_q <= c_rn;
        rd_q <= c_rd;
        rs_q <= c_rs;
        // A zero value reduces straight to 0/1.
        qn_q <= '0;
        qd_q <= P'(1);
        if (op_q == rau_pkg::OpCmp) begin
          wr_less_q <= (c_rn != '0) && c_rs;
          wr_eq_q   <= (c_rn == '0);
        end
      end
      rau_pkg::SGcd: begin
        if (gcd_sts.done) begin
          g_q <= gcd_g;
        end
      end
      rau_pkg::SDiv: begin
        if (div_sts.done) begin
          if (di_q) begin
            qd_q <= div_q;
          end else begin
            qn_q <= div_q;
          end
        end
      end
      rau_pkg::SFin: begin
        if (fin_ovf) begin
          wr_st_q <= rau_pkg::StOverflow;
        end else begin
          wr_num_q <= rau_pkg::FieldBits'($signed(fin_nw));
          wr_den_q <= rau_pkg::DenOutBits'(qd_q[W-2:0]);
        end
      end
      rau_pkg::SOut: begin
        if (out_free) begin
          out_num_q  <= wr_num_q;
          out_den_q  <= wr_den_q;
          out_less_q <= wr_less_q;
          out_eq_q   <= wr_eq_q;
          out_st_q   <= wr_st_q;
        end
      end
      default: ;
    endcase
  end

  rau_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sts_o   (mul_sts),
    .prod_o  (mul_p)
  );

  rau_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .x_i     (c_rn),
    .y_i     (c_rd),
    .sts_o   (gcd_sts),
    .gcd_o   (gcd_g)
  );

  rau_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_n),
    .den_i   (g_q),
    .sts_o   (div_sts),
    .quo_o   (div_q)
  );

  assign out_valid_o = out_valid_q;
  assign res_num_o   = out_num_q;
  assign res_den_o   = out_den_q;
  assign is_less_o   = out_less_q;
  assign is_equal_o  = out_eq_q;
  assign status_o    = out_st_q;

  `RAU_ASSERT_SAME(a_err_zero, out_valid_o && (status_o != rau_pkg::StOk), (res_num_o == '0) && (res_den_o == '0), "error beat carries a nonzero fraction")
  `RAU_ASSERT_SAME(a_mul_free, mul_start, !mul_sts.busy, "multiplier restarted while busy")
  `RAU_ASSERT_SAME(a_gcd_nz, gcd_sts.done, gcd_g != '0, "GCD unit returned zero")
  `RAU_ASSERT_NEXT(a_leave_idle, in_valid_i && in_ready_o, state_q != rau_pkg::SIdle, "accepted beat left controller idle")

endmodule

// ----- dv/rational_arithmetic_unit_core_test.sv -----
// Self-checking testbench for rational_arithmetic_unit_core: directed corner
// beats, then random beats with random idling on both channels.
// Depends on rau_pkg and the core RTL.
module rational_arithmetic_unit_core_test;

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               less;
    logic               equal;
    logic [1:0]         status;
  } quotient_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] opcode_i = '0;
  logic signed [31:0] a_num_i = '0, a_den_i = '0, b_num_i = '0, b_den_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] res_num_o;
  logic [30:0] res_den_o;
  logic is_less_o, is_equal_o;
  logic [1:0] status_o;

  quotient_t pending_q[$];
  int errors = 0;
  longint cycles = 0;
  bit calm = 1'b0;

  rational_arithmetic_unit_core uut (.*);

  always #1 clk_i = ~clk_i;

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic quotient_t predict(logic [2:0] op, logic [31:0] an_r,
                                        logic [31:0] ad_r, logic [31:0] bn_r,
                                        logic [31:0] bd_r);
    quotient_t r;
    logic sa, sb, rs, s2;
    logic [63:0] an, ad, bn, bd, rn, rd, m1, m2, g;
    r = '0;
    if (op > rau_pkg::OpNorm) return r;
    // The negation stays at 32 bits so that the most negative word gives 2^31.
    an = {32'd0, (an_r[31] ? -an_r : an_r)};
    ad = {32'd0, (ad_r[31] ? -ad_r : ad_r)};
    bn = {32'd0, (bn_r[31] ? -bn_r : bn_r)};
    bd = {32'd0, (bd_r[31] ? -bd_r : bd_r)};
    sa = (an_r[31] != ad_r[31]) && an != 0;
    sb = (bn_r[31] != bd_r[31]) && bn != 0;
    if (ad == 0 || (op != rau_pkg::OpNorm && bd == 0)
        || (op == rau_pkg::OpDiv && bn == 0)) begin
      r.status = rau_pkg::StZeroDen;
      return r;
    end
    rd = 1;
    case (op)
      rau_pkg::OpAdd, rau_pkg::OpSub, rau_pkg::OpCmp: begin
        m1 = an * bd;
        m2 = bn * ad;
        s2 = (op != rau_pkg::OpAdd) ? !sb : sb;
        if (sa == s2) begin
          rs = sa; rn = m1 + m2;
        end else if (m1 >= m2) begin
          rs = sa; rn = m1 - m2;
        end else begin
          rs = s2; rn = m2 - m1;
        end
        if (op == rau_pkg::OpCmp) begin
          r.less = (rn != 0) && rs;
          r.equal = (rn == 0);
          return r;
        end
        rd = ad * bd;
      end
      rau_pkg::OpMul: begin
        rn = an * bn; rd = ad * bd; rs = sa != sb;
      end
      rau_pkg::OpDiv: begin
        rn = an * bd; rd = ad * bn; rs = sa != sb;
      end
      default: begin
        rn = an; rd = ad; rs = sa;
      end
    endcase
    if (rn == 0) begin
      rs = 1'b0;
      rd = 1;
    end else begin
      g = gcd64(rn, rd);
      rn = rn / g;
      rd = rd / g;
    end
    if (rd > 64'h7FFF_FFFF || rn > (rs ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
      r.status = rau_pkg::StOverflow;
      return r;
    end
    r.num = rs ? -rn[31:0] : rn[31:0];
    r.den = rd[30:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3_000_000) begin
      $display("timeout at %0t", $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 8);
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk_i) begin
    quotient_t want, got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{res_num_o, res_den_o, is_less_o, is_equal_o, status_o};
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: expected num %0d den %0d lt %b eq %b st %0d,",
                   $time, want.num, want.den, want.less, want.equal, want.status);
          $display("  got num %0d den %0d lt %b eq %b st %0d",
                   got.num, got.den, got.less, got.equal, got.status);
        end
      end
    end
  end

  // Valid stays high after an accept until the next beat or an idle cycle
  // takes its place, so each time step sees one update of it.
  task automatic send_beat(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    while (!calm && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    opcode_i <= op;
    a_num_i <= an;
    a_den_i <= ad;
    b_num_i <= bn;
    b_den_i <= bd;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_q.push_back(predict(op, an, ad, bn, bd));
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($urandom_range(40)) - 20;
      2: return {1'b1, 31'($urandom_range(3))};
      3: return {1'b0, {31{1'b1}}} - 32'($urandom_range(3));
      default: return 32'($urandom_range(2000)) - 1000;
    endcase
  endfunction

  task automatic test_directed();
    send_beat(rau_pkg::OpAdd, 1, 2, 1, 3);
    send_beat(rau_pkg::OpSub, 1, 2, 1, 2);
    send_beat(rau_pkg::OpMul, -3, 4, 8, -9);
    send_beat(rau_pkg::OpDiv, 5, 7, 0, 3);
    send_beat(rau_pkg::OpDiv, 32'h7FFF_FFFF, 1, 1, 32'h7FFF_FFFF);
    send_beat(rau_pkg::OpCmp, 1, 3, 1, 2);
    send_beat(rau_pkg::OpCmp, 2, 4, 1, 2);
    send_beat(rau_pkg::OpCmp, -1, 1, -1, -1);
    send_beat(rau_pkg::OpNorm, 6, -4, 0, 0);
    send_beat(rau_pkg::OpNorm, 32'h8000_0000, 1, 0, 0);
    send_beat(rau_pkg::OpNorm, 32'h8000_0000, -1, 0, 0);
    send_beat(rau_pkg::OpNorm, 0, -5, 0, 0);
    send_beat(rau_pkg::OpAdd, 1, 0, 1, 1);
    send_beat(rau_pkg::OpCmp, 1, 1, 1, 0);
    send_beat(rau_pkg::OpNorm, 1, 0, 1, 1);
    send_beat(rau_pkg::OpMul, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
    send_beat(rau_pkg::OpMul, 32'h8000_0000, 1, -1, 1);
    send_beat(rau_pkg::OpAdd, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'hFFFF_FFFF,
              32'h8000_0000);
    send_beat(3'd6, 1, 1, 1, 1);
    send_beat(3'd7, -1, -1, -1, -1);
    send_beat(rau_pkg::OpSub, 0, 32'h8000_0000, 0, 32'h7FFF_FFFF);
  endtask

  task automatic test_random(int count);
    logic [2:0] op;
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 2) && (i < count / 2 + 100);
      op = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
      send_beat(op, pick_word(), pick_word(), pick_word(), pick_word());
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(800);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
